// File: hw/rtl/caldate_pkg.sv
// Shared constants, codes and calendar helper functions for the date counter.
package caldate_pkg;

  // Field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned ORDER_W = 2;

  typedef logic [OP_W-1:0]    op_t;
  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [YEAR_W-1:0]  year_t;
  typedef logic [ORDER_W-1:0] order_t;

  // Opcodes
  localparam op_t OP_INC = 2'd0;
  localparam op_t OP_DEC = 2'd1;
  localparam op_t OP_SET = 2'd2;
  localparam op_t OP_CMP = 2'd3;

  // Compare results: stored date versus given date
  localparam order_t ORD_EARLIER = 2'd0;
  localparam order_t ORD_EQUAL   = 2'd1;
  localparam order_t ORD_LATER   = 2'd2;

  // Calendar constants
  localparam year_t  YEAR_MIN   = 12'd1970;
  localparam year_t  YEAR_MAX   = 12'd2500;
  localparam year_t  YEAR_RESET = 12'd1970;
  localparam day_t   DAY_FIRST  = 5'd1;
  localparam month_t MONTH_JAN  = 4'd1;
  localparam month_t MONTH_FEB  = 4'd2;
  localparam month_t MONTH_APR  = 4'd4;
  localparam month_t MONTH_JUN  = 4'd6;
  localparam month_t MONTH_SEP  = 4'd9;
  localparam month_t MONTH_NOV  = 4'd11;
  localparam month_t MONTH_DEC  = 4'd12;
  localparam day_t   LEN_LONG   = 5'd31;
  localparam day_t   LEN_SHORT  = 5'd30;
  localparam day_t   LEN_FEB    = 5'd28;
  localparam day_t   LEN_FEB_LEAP = 5'd29;

  // y / 25 for 12-bit y: (y * 1311) >> 15 is exact over 0..4095
  localparam logic [10:0] RECIP_25   = 11'd1311;
  localparam int unsigned RECIP_SHIFT = 15;
  localparam logic [4:0]  DIV_25     = 5'd25;

  // Gregorian leap rule. A century (divisible by 4 and 25) is leap only
  // when also divisible by 16, which together gives divisible by 400.
  function automatic logic is_leap(input year_t y);
    logic [22:0] prod;
    logic [7:0]  quot;
    logic [12:0] back;
    year_t       rem;
    logic        div4;
    logic        div100;
    prod   = 23'(y) * 23'(RECIP_25);
    quot   = prod[RECIP_SHIFT +: 8];
    back   = 13'(quot) * 13'(DIV_25);
    rem    = y - back[YEAR_W-1:0];
    div4   = (y[1:0] == 2'b00);
    div100 = div4 && (rem == '0);
    return div4 && (!div100 || (y[3:0] == 4'b0000));
  endfunction

  // Days in month m; leap selects the February length
  function automatic day_t month_len(input month_t m, input logic leap);
    day_t len;
    len = LEN_LONG;
    if (m == MONTH_FEB) begin
      len = leap ? LEN_FEB_LEAP : LEN_FEB;
    end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
      len = LEN_SHORT;
    end
    return len;
  endfunction

endpackage

// File: hw/rtl/caldate_in_if.sv
// Request channel into the date counter: handshake plus opcode and date argument.
interface caldate_in_if;
  import caldate_pkg::*;

  logic   valid;
  logic   ready;
  op_t    opcode;
  day_t   arg_day;
  month_t arg_month;
  year_t  arg_year;

  modport source (output valid, output opcode, output arg_day, output arg_month,
                  output arg_year, input ready);
  modport sink   (input valid, input opcode, input arg_day, input arg_month,
                  input arg_year, output ready);
endinterface

// File: hw/rtl/caldate_out_if.sv
// Result channel out of the date counter: handshake plus current date, reject and order.
interface caldate_out_if;
  import caldate_pkg::*;

  logic   valid;
  logic   ready;
  day_t   cur_day;
  month_t cur_month;
  year_t  cur_year;
  logic   rejected;
  order_t order;

  modport source (output valid, output cur_day, output cur_month, output cur_year,
                  output rejected, output order, input ready);
  modport sink   (input valid, input cur_day, input cur_month, input cur_year,
                  input rejected, input order, output ready);
endinterface

// File: hw/rtl/calendar_date_counter.sv
// Top level of the Gregorian calendar date counter.
//
// Holds one date (day, month, year), reset to 1 January 1970.
// in_ch carries one request per handshake: an opcode (increment day,
// decrement day, set date, compare with date) and a date argument.
// out_ch returns exactly one result per request: the stored date after
// the operation, a reject flag for an invalid set, and the compare order.
// A request is registered in the staging register on acceptance and is
// resolved into the result register once the result slot is free, which
// raises out_ch.valid. One request is taken every cycle while out_ch.ready
// stays high; the rate is set by the single update of the date registers
// per cycle. The leap test uses a constant reciprocal multiply for the
// century check.
// When out_ch.ready is low with a result pending, the result register holds,
// the staged request waits, and in_ch.ready drops once the staging register is also full.
// Reset (rst_n low, synchronous) clears both valid flags and reloads the
// stored date.
module calendar_date_counter (
  input logic          clk,
  input logic          rst_n,
  caldate_in_if.sink   in_ch,
  caldate_out_if.source out_ch
);
  import caldate_pkg::*;

  // Staged request
  logic   s1_valid_r;
  op_t    s1_op_r;
  day_t   s1_day_r;
  month_t s1_month_r;
  year_t  s1_year_r;

  // Stored date
  day_t   day_r,   day_nxt;
  month_t month_r, month_nxt;
  year_t  year_r,  year_nxt;

  // Result register
  logic   out_valid_r;
  day_t   out_day_r;
  month_t out_month_r;
  year_t  out_year_r;
  logic   out_rej_r, rej_nxt;
  order_t out_ord_r, ord_nxt;

  logic   advance;
  logic   in_take;
  logic   cur_leap;
  logic   arg_leap;
  day_t   cur_len;
  month_t prev_month;
  day_t   prev_len;
  logic   set_ok;
  logic [DAY_W+MONTH_W+YEAR_W-1:0] cur_key;
  logic [DAY_W+MONTH_W+YEAR_W-1:0] arg_key;

  // Handshake: the staged request moves on when the result slot is free
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  // Calendar helpers on the stored and the given date
  assign cur_leap   = is_leap(year_r);
  assign arg_leap   = is_leap(s1_year_r);
  assign cur_len    = month_len(month_r, cur_leap);
  assign prev_month = (month_r <= MONTH_JAN) ? MONTH_DEC : (month_r - MONTH_JAN);
  // Stepping back into February never changes the year, so cur_leap fits
  assign prev_len   = month_len(prev_month, cur_leap);
  assign set_ok     = (s1_year_r >= YEAR_MIN) && (s1_year_r <= YEAR_MAX) &&
                      (s1_month_r >= MONTH_JAN) && (s1_month_r <= MONTH_DEC) &&
                      (s1_day_r >= DAY_FIRST) &&
                      (s1_day_r <= month_len(s1_month_r, arg_leap));
  // Year, then month, then day: one unsigned compare of the packed key
  assign cur_key    = {year_r, month_r, day_r};
  assign arg_key    = {s1_year_r, s1_month_r, s1_day_r};

  // Next date and result flags
  always_comb begin
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    rej_nxt   = 1'b0;
    ord_nxt   = ORD_EARLIER;
    unique case (s1_op_r)
      OP_INC: begin
        if (day_r < cur_len) begin
          day_nxt = day_r + DAY_FIRST;
        end else begin
          day_nxt = DAY_FIRST;
          if (month_r >= MONTH_DEC) begin
            month_nxt = MONTH_JAN;
            year_nxt  = year_r + YEAR_W'(1);
          end else begin
            month_nxt = month_r + MONTH_JAN;
          end
        end
      end
      OP_DEC: begin
        if (day_r > DAY_FIRST) begin
          day_nxt = day_r - DAY_FIRST;
        end else begin
          month_nxt = prev_month;
          day_nxt   = prev_len;
          if (month_r <= MONTH_JAN) begin
            year_nxt = year_r - YEAR_W'(1);
          end
        end
      end
      OP_SET: begin
        if (set_ok) begin
          day_nxt   = s1_day_r;
          month_nxt = s1_month_r;
          year_nxt  = s1_year_r;
        end else begin
          rej_nxt = 1'b1;
        end
      end
      OP_CMP: begin
        if (cur_key == arg_key) begin
          ord_nxt = ORD_EQUAL;
        end else if (cur_key < arg_key) begin
          ord_nxt = ORD_EARLIER;
        end else begin
          ord_nxt = ORD_LATER;
        end
      end
      default: begin
        rej_nxt = 1'b0;
      end
    endcase
  end

  // Input staging register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (in_take) begin
      s1_op_r    <= in_ch.opcode;
      s1_day_r   <= in_ch.arg_day;
      s1_month_r <= in_ch.arg_month;
      s1_year_r  <= in_ch.arg_year;
    end
  end

  // Stored date
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r   <= DAY_FIRST;
      month_r <= MONTH_JAN;
      year_r  <= YEAR_RESET;
    end else if (advance) begin
      day_r   <= day_nxt;
      month_r <= month_nxt;
      year_r  <= year_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (advance) begin
      out_day_r   <= day_nxt;
      out_month_r <= month_nxt;
      out_year_r  <= year_nxt;
      out_rej_r   <= rej_nxt;
      out_ord_r   <= ord_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.cur_day   = out_day_r;
  assign out_ch.cur_month = out_month_r;
  assign out_ch.cur_year  = out_year_r;
  assign out_ch.rejected  = out_rej_r;
  assign out_ch.order     = out_ord_r;

  // Stored date is always a real calendar day
  a_date_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (month_r >= MONTH_JAN) && (month_r <= MONTH_DEC) && (day_r >= DAY_FIRST) &&
    (day_r <= month_len(month_r, is_leap(year_r))))
    else $error("stored date is not a valid calendar day");

  // A pending result always mirrors the stored date
  a_out_mirrors_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_day_r == day_r) && (out_month_r == month_r) &&
                    (out_year_r == year_r))
    else $error("pending result differs from stored date");

  // A rejected set never carries a compare order
  a_reject_no_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rej_r) |-> (out_ord_r == ORD_EARLIER))
    else $error("rejected result carries an order");

  // Compare leaves the date untouched
  a_cmp_keeps_date: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (s1_op_r == OP_CMP)) |=> ($stable(day_r) && $stable(month_r) &&
                                          $stable(year_r)))
    else $error("compare changed the stored date");

  // Back-pressure on the input only with a request already staged
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r)
    else $error("input stalled with empty staging register");

endmodule
